/* rtl/core/ites_pkg.sv */
// Shared widths and the output saturation helper for the thermoelastic stress block.
package ites_pkg;

  localparam int StrainW = 32;  // strain, 30 fractional bits
  localparam int TempW   = 16;  // temperature rise, 4 fractional bits
  localparam int CfgW    = 32;  // widest register
  localparam int Mu2W    = 33;  // 2*mu, signed container
  localparam int TrW     = 34;  // trace of the strain
  localparam int ProdW   = 65;  // 2*mu*eps
  localparam int SqW     = 63;  // eps^2, never negative
  localparam int LtW     = 66;  // lambda*tr
  localparam int Lt2W    = 99;  // lambda*tr^2
  localparam int ThW     = 84;  // thermal term, 52 fractional bits
  localparam int OutW    = 48;  // result width
  localparam int SatW    = 104; // container for rounded values before clamping
  localparam int NumLanes = 6;

  // Clamp a rounded value to the signed result range.
  function automatic logic signed [OutW-1:0] sat_out(input logic signed [SatW-1:0] v);
    logic all_ones;
    logic all_zeros;
    logic signed [OutW-1:0] res;
    all_ones  = &v[SatW-1:OutW-1];
    all_zeros = ~|v[SatW-1:OutW-1];
    if (all_ones || all_zeros) begin
      res = v[OutW-1:0];
    end else if (v[SatW-1]) begin
      res = {1'b1, {(OutW-1){1'b0}}};
    end else begin
      res = {1'b0, {(OutW-1){1'b1}}};
    end
    return res;
  endfunction

endpackage

/* rtl/core/isotropic_thermoelastic_stress.sv */
// Top level of the isotropic thermoelastic stress block.
//
// Usage notes:
// - Request channel: drive the six strain components and the temperature rise
//   with start high; the request is taken at that clock edge (busy stays low,
//   the pipeline never holds off a request). One request per cycle is fine.
// - Result channel: valid_o is high for exactly one cycle with the six stress
//   components and the strain energy density. The receiver cannot stall; the
//   result must be taken in that cycle.
// - Pipeline: a request passes the capture, products, partial products,
//   partial sums, final sums and round/clamp registers, in that order.
//   Throughput: one request per cycle, set by the six strain lanes and the
//   volumetric path each taking a new tensor every cycle.
// - Configuration: cfg_we_i with cfg_idx_i 0 = lambda, 1 = mu, 2 = alpha,
//   data on cfg_wdata_i (masked to the register width). Write only while no
//   request is in flight; unknown indexes are ignored.
// - Reset: clears the configuration registers to zero and drops all in-flight requests.
// - Multipliers are at most about 35x34 bits, each followed by a register.
module isotropic_thermoelastic_stress (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // request channel
  input  logic                                start,
  output logic                                busy,
  input  logic signed [ites_pkg::StrainW-1:0] strain_xx_i,
  input  logic signed [ites_pkg::StrainW-1:0] strain_yy_i,
  input  logic signed [ites_pkg::StrainW-1:0] strain_zz_i,
  input  logic signed [ites_pkg::StrainW-1:0] strain_xy_i,
  input  logic signed [ites_pkg::StrainW-1:0] strain_xz_i,
  input  logic signed [ites_pkg::StrainW-1:0] strain_yz_i,
  input  logic signed [ites_pkg::TempW-1:0]   temperature_change_i,
  // result channel
  output logic                                valid_o,
  output logic signed [ites_pkg::OutW-1:0]    stress_xx_o,
  output logic signed [ites_pkg::OutW-1:0]    stress_yy_o,
  output logic signed [ites_pkg::OutW-1:0]    stress_zz_o,
  output logic signed [ites_pkg::OutW-1:0]    stress_xy_o,
  output logic signed [ites_pkg::OutW-1:0]    stress_xz_o,
  output logic signed [ites_pkg::OutW-1:0]    stress_yz_o,
  output logic signed [ites_pkg::OutW-1:0]    energy_density_o,
  // configuration write port
  input  logic                                cfg_we_i,
  input  logic [1:0]                          cfg_idx_i,
  input  logic [ites_pkg::CfgW-1:0]           cfg_wdata_i
);

  typedef enum logic [1:0] {
    CfgLambda = 2'd0,
    CfgShear  = 2'd1,
    CfgAlpha  = 2'd2
  } cfg_idx_e;

  localparam int MuW    = 31;
  localparam int Depth  = 6;   // capture through round/clamp

  // configuration registers
  logic signed [ites_pkg::CfgW-1:0] lam_q;
  logic        [MuW-1:0]            mu_q;
  logic        [ites_pkg::CfgW-1:0] alpha_q;
  logic signed [ites_pkg::Mu2W-1:0] mu2;

  // request capture (stage A)
  logic                                accept;
  logic signed [ites_pkg::StrainW-1:0] strain_in [ites_pkg::NumLanes];
  logic signed [ites_pkg::StrainW-1:0] strain_q  [ites_pkg::NumLanes];
  logic signed [ites_pkg::TempW-1:0]   dt_q;
  logic signed [ites_pkg::TrW-1:0]     tr_d, tr_q;
  logic [Depth-1:0]                    vld_d, vld_q;

  // lane and volumetric results
  logic signed [ites_pkg::ProdW-1:0] prod   [ites_pkg::NumLanes];
  logic        [ites_pkg::SqW-1:0]   sq     [ites_pkg::NumLanes];
  logic signed [ites_pkg::LtW-1:0]   lt;
  logic signed [ites_pkg::Lt2W-1:0]  lt2;
  logic signed [ites_pkg::ThW-1:0]   th;
  logic signed [ites_pkg::OutW-1:0]  stress [ites_pkg::NumLanes];
  logic signed [ites_pkg::OutW-1:0]  energy;

  assign busy   = 1'b0;  // fully pipelined, never refuses a request
  assign accept = start && !busy;
  assign mu2    = $signed({2'b00, mu_q}) <<< 1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lam_q   <= '0;
      mu_q    <= '0;
      alpha_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgLambda: lam_q   <= $signed(cfg_wdata_i);
        CfgShear:  mu_q    <= cfg_wdata_i[MuW-1:0];
        CfgAlpha:  alpha_q <= cfg_wdata_i;
        default:   ;
      endcase
    end
  end

  always_comb begin
    strain_in[0] = strain_xx_i;
    strain_in[1] = strain_yy_i;
    strain_in[2] = strain_zz_i;
    strain_in[3] = strain_xy_i;
    strain_in[4] = strain_xz_i;
    strain_in[5] = strain_yz_i;
    tr_d = ites_pkg::TrW'(strain_xx_i) + ites_pkg::TrW'(strain_yy_i)
         + ites_pkg::TrW'(strain_zz_i);
    vld_d = {vld_q[Depth-2:0], accept};
  end

  // valid marker follows the request down the pipe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // payload capture; no reset needed
  always_ff @(posedge clk_i) begin
    strain_q <= strain_in;
    dt_q     <= temperature_change_i;
    tr_q     <= tr_d;
  end

  // one lane per strain component
  for (genvar g = 0; g < ites_pkg::NumLanes; g++) begin : g_lane
    ites_lane u_lane (
      .clk_i    (clk_i),
      .strain_i (strain_q[g]),
      .mu2_i    (mu2),
      .prod_o   (prod[g]),
      .sq_o     (sq[g])
    );
  end

  // trace-driven terms and thermal load
  ites_volume u_volume (
    .clk_i   (clk_i),
    .tr_i    (tr_q),
    .dt_i    (dt_q),
    .lam_i   (lam_q),
    .mu2_i   (mu2),
    .alpha_i (alpha_q),
    .lt_o    (lt),
    .lt2_o   (lt2),
    .th_o    (th)
  );

  ites_merge u_merge (
    .clk_i    (clk_i),
    .mu2_i    (mu2),
    .prod_i   (prod),
    .sq_i     (sq),
    .lt_i     (lt),
    .lt2_i    (lt2),
    .th_i     (th),
    .stress_o (stress),
    .energy_o (energy)
  );

  assign valid_o          = vld_q[Depth-1];
  assign stress_xx_o      = stress[0];
  assign stress_yy_o      = stress[1];
  assign stress_zz_o      = stress[2];
  assign stress_xy_o      = stress[3];
  assign stress_xz_o      = stress[4];
  assign stress_yz_o      = stress[5];
  assign energy_density_o = energy;

endmodule

/* rtl/core/ites_lane.sv */
// One strain component lane: 2*mu*eps and eps^2, registered.
module ites_lane (
  input  logic                                clk_i,
  input  logic signed [ites_pkg::StrainW-1:0] strain_i,
  input  logic signed [ites_pkg::Mu2W-1:0]    mu2_i,
  output logic signed [ites_pkg::ProdW-1:0]   prod_o,
  output logic        [ites_pkg::SqW-1:0]     sq_o
);

  logic signed [ites_pkg::ProdW-1:0]     prod_d, prod_q;
  logic signed [2*ites_pkg::StrainW-1:0] sq_full;
  logic        [ites_pkg::SqW-1:0]       sq_d, sq_q;

  always_comb begin
    prod_d  = ites_pkg::ProdW'(mu2_i) * ites_pkg::ProdW'(strain_i);
    sq_full = (2*ites_pkg::StrainW)'(strain_i) * (2*ites_pkg::StrainW)'(strain_i);
    sq_d    = sq_full[ites_pkg::SqW-1:0];
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    sq_q   <= sq_d;
  end

  assign prod_o = prod_q;
  assign sq_o   = sq_q;

endmodule

/* rtl/core/ites_volume.sv */
// Volumetric path: lambda*tr, lambda*tr^2 and the thermal term, three stages.
module ites_volume (
  input  logic                                clk_i,
  input  logic signed [ites_pkg::TrW-1:0]     tr_i,
  input  logic signed [ites_pkg::TempW-1:0]   dt_i,
  input  logic signed [ites_pkg::CfgW-1:0]    lam_i,
  input  logic signed [ites_pkg::Mu2W-1:0]    mu2_i,
  input  logic        [ites_pkg::CfgW-1:0]    alpha_i,
  output logic signed [ites_pkg::LtW-1:0]     lt_o,
  output logic signed [ites_pkg::Lt2W-1:0]    lt2_o,
  output logic signed [ites_pkg::ThW-1:0]     th_o
);

  localparam int Tr2W = 2*ites_pkg::TrW;
  localparam int T2W  = 66;            // tr^2 magnitude bits
  localparam int T2H  = T2W / 2;       // split point for lambda*tr^2
  localparam int AdW  = 49;            // alpha*dT
  localparam int AdL  = 24;            // split point for k*alpha*dT
  localparam int KW   = 35;            // 3*lambda + 2*mu
  localparam int PlW  = 66;            // lambda * half of tr^2
  localparam int PtW  = 60;            // k * half of alpha*dT

  logic signed [Tr2W-1:0] tr2_full;

  // stage B
  logic signed [ites_pkg::LtW-1:0] lt_b_d, lt_b_q;
  logic        [T2W-1:0]           tr2_b_d, tr2_b_q;
  logic signed [AdW-1:0]           ad_b_d, ad_b_q;
  logic signed [KW-1:0]            k_b_d, k_b_q;

  // stage C
  logic signed [ites_pkg::LtW-1:0] lt_c_q;
  logic signed [PlW-1:0]           l2lo_c_d, l2lo_c_q, l2hi_c_d, l2hi_c_q;
  logic signed [PtW-1:0]           thlo_c_d, thlo_c_q, thhi_c_d, thhi_c_q;

  // stage D
  logic signed [ites_pkg::LtW-1:0]  lt_d_q;
  logic signed [ites_pkg::Lt2W-1:0] lt2_d_d, lt2_d_q;
  logic signed [ites_pkg::ThW-1:0]  th_d_d, th_d_q;

  always_comb begin
    lt_b_d   = ites_pkg::LtW'(lam_i) * ites_pkg::LtW'(tr_i);
    tr2_full = Tr2W'(tr_i) * Tr2W'(tr_i);
    tr2_b_d  = tr2_full[T2W-1:0];
    ad_b_d   = AdW'($signed({1'b0, alpha_i})) * AdW'(dt_i);
    k_b_d    = KW'(lam_i) + (KW'(lam_i) <<< 1) + KW'(mu2_i);
  end

  always_comb begin
    l2lo_c_d = PlW'(lam_i) * PlW'($signed({1'b0, tr2_b_q[T2H-1:0]}));
    l2hi_c_d = PlW'(lam_i) * PlW'($signed({1'b0, tr2_b_q[T2W-1:T2H]}));
    thlo_c_d = PtW'(k_b_q) * PtW'($signed({1'b0, ad_b_q[AdL-1:0]}));
    thhi_c_d = PtW'(k_b_q) * PtW'($signed(ad_b_q[AdW-1:AdL]));
  end

  always_comb begin
    lt2_d_d = (ites_pkg::Lt2W'(l2hi_c_q) <<< T2H) + ites_pkg::Lt2W'(l2lo_c_q);
    th_d_d  = (ites_pkg::ThW'(thhi_c_q) <<< AdL) + ites_pkg::ThW'(thlo_c_q);
  end

  always_ff @(posedge clk_i) begin
    lt_b_q   <= lt_b_d;
    tr2_b_q  <= tr2_b_d;
    ad_b_q   <= ad_b_d;
    k_b_q    <= k_b_d;
    lt_c_q   <= lt_b_q;
    l2lo_c_q <= l2lo_c_d;
    l2hi_c_q <= l2hi_c_d;
    thlo_c_q <= thlo_c_d;
    thhi_c_q <= thhi_c_d;
    lt_d_q   <= lt_c_q;
    lt2_d_q  <= lt2_d_d;
    th_d_q   <= th_d_d;
  end

  assign lt_o  = lt_d_q;
  assign lt2_o = lt2_d_q;
  assign th_o  = th_d_q;

endmodule

/* rtl/core/ites_merge.sv */
// Merge stage: combines lane and volumetric terms, rounds and clamps the results.
module ites_merge (
  input  logic                                clk_i,
  input  logic signed [ites_pkg::Mu2W-1:0]    mu2_i,
  input  logic signed [ites_pkg::ProdW-1:0]   prod_i [ites_pkg::NumLanes],
  input  logic        [ites_pkg::SqW-1:0]     sq_i   [ites_pkg::NumLanes],
  input  logic signed [ites_pkg::LtW-1:0]     lt_i,
  input  logic signed [ites_pkg::Lt2W-1:0]    lt2_i,
  input  logic signed [ites_pkg::ThW-1:0]     th_i,
  output logic signed [ites_pkg::OutW-1:0]    stress_o [ites_pkg::NumLanes],
  output logic signed [ites_pkg::OutW-1:0]    energy_o
);

  localparam int SsW  = 66;          // weighted sum of squares
  localparam int SsH  = SsW / 2;
  localparam int PsW  = 67;          // 2*mu * half of that sum
  localparam int NW   = 88;          // normal stress, 52 fractional bits
  localparam int UW   = 102;         // twice the energy, 68 fractional bits
  localparam int NSh  = 44;
  localparam int SSh  = 30;
  localparam int USh  = 61;
  localparam int NDiag = 3;

  localparam logic signed [NW-1:0]                NHalf = NW'(1) <<< (NSh-1);
  localparam logic signed [ites_pkg::ProdW-1:0]   SHalf = ites_pkg::ProdW'(1) <<< (SSh-1);
  localparam logic signed [UW-1:0]                UHalf = UW'(1) <<< (USh-1);

  logic signed [ites_pkg::ProdW-1:0] prod_c_q [ites_pkg::NumLanes];
  logic signed [ites_pkg::ProdW-1:0] prod_d_q [ites_pkg::NumLanes];
  logic        [SsW-1:0]             ss_c_d, ss_c_q;
  logic signed [PsW-1:0]             plo_d_d, plo_d_q, phi_d_d, phi_d_q;

  logic signed [NW-1:0]              norm_e_d [NDiag];
  logic signed [NW-1:0]              norm_e_q [NDiag];
  logic signed [ites_pkg::ProdW-1:0] shear_e_q [NDiag];
  logic signed [UW-1:0]              eng_e_d, eng_e_q;

  logic signed [NW-1:0]              norm_r [NDiag];
  logic signed [ites_pkg::ProdW-1:0] shear_r [NDiag];
  logic signed [UW-1:0]              eng_r;
  logic signed [ites_pkg::OutW-1:0]  stress_d [ites_pkg::NumLanes];
  logic signed [ites_pkg::OutW-1:0]  stress_q [ites_pkg::NumLanes];
  logic signed [ites_pkg::OutW-1:0]  energy_d, energy_q;

  // stage C: diagonal squares plus twice the shear squares
  always_comb begin
    ss_c_d = SsW'(sq_i[0]) + SsW'(sq_i[1]) + SsW'(sq_i[2])
           + ((SsW'(sq_i[3]) + SsW'(sq_i[4]) + SsW'(sq_i[5])) << 1);
  end

  // stage D: 2*mu times the sum, split in two halves
  always_comb begin
    plo_d_d = PsW'(mu2_i) * PsW'($signed({1'b0, ss_c_q[SsH-1:0]}));
    phi_d_d = PsW'(mu2_i) * PsW'($signed({1'b0, ss_c_q[SsW-1:SsH]}));
  end

  // stage E: final sums
  always_comb begin
    for (int i = 0; i < NDiag; i++) begin
      norm_e_d[i] = ((NW'(lt_i) + NW'(prod_d_q[i])) <<< 14) - NW'(th_i);
    end
    eng_e_d = UW'(lt2_i) + (UW'(phi_d_q) <<< SsH) + UW'(plo_d_q);
  end

  // stage F: round half up, clamp
  always_comb begin
    for (int i = 0; i < NDiag; i++) begin
      norm_r[i]        = (norm_e_q[i] + NHalf) >>> NSh;
      shear_r[i]       = (shear_e_q[i] + SHalf) >>> SSh;
      stress_d[i]      = ites_pkg::sat_out(ites_pkg::SatW'(norm_r[i]));
      stress_d[i+NDiag] = ites_pkg::sat_out(ites_pkg::SatW'(shear_r[i]));
    end
    eng_r    = (eng_e_q + UHalf) >>> USh;
    energy_d = ites_pkg::sat_out(ites_pkg::SatW'(eng_r));
  end

  always_ff @(posedge clk_i) begin
    prod_c_q <= prod_i;
    prod_d_q <= prod_c_q;
    ss_c_q   <= ss_c_d;
    plo_d_q  <= plo_d_d;
    phi_d_q  <= phi_d_d;
    norm_e_q <= norm_e_d;
    for (int i = 0; i < NDiag; i++) begin
      shear_e_q[i] <= prod_d_q[i+NDiag];
    end
    eng_e_q  <= eng_e_d;
    stress_q <= stress_d;
    energy_q <= energy_d;
  end

  assign stress_o = stress_q;
  assign energy_o = energy_q;

endmodule

/* dv/tb_top.sv */
// Self-checking testbench for the isotropic thermoelastic stress block.
module tb_top;

  import ites_pkg::*;

  // Pipeline depth from the accepting edge to the edge that ends valid_o.
  localparam int PIPE_LAT       = 6;
  // Idle cycles (nothing accepted, no result, no register write) before the run is abandoned.
  localparam int STALL_LIMIT    = 500;
  localparam int NUM_PHASES     = 8;
  localparam int ITEMS_PER_PHASE = 125;
  localparam int MAX_GAP        = 8;
  localparam int MAX_REPORTS    = 10;

  localparam logic signed [127:0] OUT_MAX = (128'sd1 <<< (OutW - 1)) - 128'sd1;
  localparam logic signed [127:0] OUT_MIN = -(128'sd1 <<< (OutW - 1));

  // Register indexes on the write port.
  typedef enum logic [1:0] {
    CFG_LAMBDA = 2'd0,
    CFG_MU     = 2'd1,
    CFG_ALPHA  = 2'd2,
    CFG_SPARE  = 2'd3   // unmapped, writes must be dropped
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ROW_CFG,   // register write, issued with the pipeline drained
    ROW_REQ,   // request checked against the predictor
    ROW_CHK    // request with a hand-typed expected result
  } row_kind_e;

  typedef struct packed {
    logic signed [StrainW-1:0] xx;
    logic signed [StrainW-1:0] yy;
    logic signed [StrainW-1:0] zz;
    logic signed [StrainW-1:0] xy;
    logic signed [StrainW-1:0] xz;
    logic signed [StrainW-1:0] yz;
    logic signed [TempW-1:0]   dt;
  } strain_req_t;

  typedef struct packed {
    logic signed [OutW-1:0] sxx;
    logic signed [OutW-1:0] syy;
    logic signed [OutW-1:0] szz;
    logic signed [OutW-1:0] sxy;
    logic signed [OutW-1:0] sxz;
    logic signed [OutW-1:0] syz;
    logic signed [OutW-1:0] energy;
  } stress_res_t;

  typedef struct packed {
    row_kind_e   kind;
    cfg_reg_e    idx;
    logic [31:0] val;
    strain_req_t req;
    stress_res_t want;
  } stim_row_t;

  // DUT connections
  logic                      clk_i;
  logic                      rst_ni;
  logic                      start;
  logic                      busy;
  logic signed [StrainW-1:0] strain_xx_i;
  logic signed [StrainW-1:0] strain_yy_i;
  logic signed [StrainW-1:0] strain_zz_i;
  logic signed [StrainW-1:0] strain_xy_i;
  logic signed [StrainW-1:0] strain_xz_i;
  logic signed [StrainW-1:0] strain_yz_i;
  logic signed [TempW-1:0]   temperature_change_i;
  logic                      valid_o;
  logic signed [OutW-1:0]    stress_xx_o;
  logic signed [OutW-1:0]    stress_yy_o;
  logic signed [OutW-1:0]    stress_zz_o;
  logic signed [OutW-1:0]    stress_xy_o;
  logic signed [OutW-1:0]    stress_xz_o;
  logic signed [OutW-1:0]    stress_yz_o;
  logic signed [OutW-1:0]    energy_density_o;
  logic                      cfg_we_i;
  logic [1:0]                cfg_idx_i;
  logic [CfgW-1:0]           cfg_wdata_i;

  isotropic_thermoelastic_stress uut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .start                (start),
    .busy                 (busy),
    .strain_xx_i          (strain_xx_i),
    .strain_yy_i          (strain_yy_i),
    .strain_zz_i          (strain_zz_i),
    .strain_xy_i          (strain_xy_i),
    .strain_xz_i          (strain_xz_i),
    .strain_yz_i          (strain_yz_i),
    .temperature_change_i (temperature_change_i),
    .valid_o              (valid_o),
    .stress_xx_o          (stress_xx_o),
    .stress_yy_o          (stress_yy_o),
    .stress_zz_o          (stress_zz_o),
    .stress_xy_o          (stress_xy_o),
    .stress_xz_o          (stress_xz_o),
    .stress_yz_o          (stress_yz_o),
    .energy_density_o     (energy_density_o),
    .cfg_we_i             (cfg_we_i),
    .cfg_idx_i            (cfg_idx_i),
    .cfg_wdata_i          (cfg_wdata_i)
  );

  // Shadow copy of the registers, updated only while the pipeline is empty.
  logic [31:0] cur_lambda;
  logic [30:0] cur_mu;
  logic [31:0] cur_alpha;

  stress_res_t pending_stress[$];   // expected results, oldest first
  stim_row_t   stim_tab[$];         // directed table
  int          mismatch_cnt;
  int          stall_cnt;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predictor. All terms are exact in 128-bit signed arithmetic (the largest,
  // lambda*tr^2 and 2*mu*sum(eps^2), stay below 2^100); each output is rounded
  // half up once and clamped to 48 bits.
  // ---------------------------------------------------------------------------
  function automatic logic signed [OutW-1:0] round_sat(input logic signed [127:0] v,
                                                        input int frac);
    logic signed [127:0] q;
    q = (v + (128'sd1 <<< (frac - 1))) >>> frac;
    if (q > OUT_MAX) q = OUT_MAX;
    else if (q < OUT_MIN) q = OUT_MIN;
    return q[OutW-1:0];
  endfunction

  function automatic stress_res_t calc_stress(input strain_req_t r);
    logic signed [127:0] e [6];
    logic signed [127:0] dt, lam, mu2, alpha, tr, lt, k, th, s, sq, u;
    stress_res_t res;
    e[0]  = {{96{r.xx[31]}}, r.xx};
    e[1]  = {{96{r.yy[31]}}, r.yy};
    e[2]  = {{96{r.zz[31]}}, r.zz};
    e[3]  = {{96{r.xy[31]}}, r.xy};
    e[4]  = {{96{r.xz[31]}}, r.xz};
    e[5]  = {{96{r.yz[31]}}, r.yz};
    dt    = {{112{r.dt[15]}}, r.dt};
    lam   = {{96{cur_lambda[31]}}, cur_lambda};
    mu2   = {96'b0, cur_mu, 1'b0};
    alpha = {96'b0, cur_alpha};

    tr = e[0] + e[1] + e[2];
    lt = lam * tr;                    // 38 fractional bits
    k  = lam + lam + lam + mu2;       // bulk term 3*lambda + 2*mu, 8 fractional bits
    th = k * (alpha * dt);            // 52 fractional bits
    // normal components: align lambda*tr + 2*mu*eps to 52 bits, subtract thermal
    s = ((lt + mu2 * e[0]) <<< 14) - th;
    res.sxx = round_sat(s, 44);
    s = ((lt + mu2 * e[1]) <<< 14) - th;
    res.syy = round_sat(s, 44);
    s = ((lt + mu2 * e[2]) <<< 14) - th;
    res.szz = round_sat(s, 44);
    res.sxy = round_sat(mu2 * e[3], 30);
    res.sxz = round_sat(mu2 * e[4], 30);
    res.syz = round_sat(mu2 * e[5], 30);
    // twice the energy density, 68 fractional bits; the halving folds into the shift
    sq = e[0] * e[0] + e[1] * e[1] + e[2] * e[2]
       + 128'sd2 * (e[3] * e[3] + e[4] * e[4] + e[5] * e[5]);
    u  = lam * (tr * tr) + mu2 * sq;
    res.energy = round_sat(u, 61);
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic strain_req_t mk_req(input logic [31:0] xx, yy, zz, xy, xz, yz,
                                          input logic [15:0] dt);
    strain_req_t r;
    r.xx = xx; r.yy = yy; r.zz = zz;
    r.xy = xy; r.xz = xz; r.yz = yz;
    r.dt = dt;
    return r;
  endfunction

  function automatic stress_res_t mk_res(input logic signed [OutW-1:0] sxx, syy, szz,
                                          sxy, sxz, syz, energy);
    stress_res_t r;
    r.sxx = sxx; r.syy = syy; r.szz = szz;
    r.sxy = sxy; r.sxz = sxz; r.syz = syz;
    r.energy = energy;
    return r;
  endfunction

  function automatic stim_row_t cfg_row(input cfg_reg_e idx, input logic [31:0] val);
    stim_row_t row;
    row      = '0;
    row.kind = ROW_CFG;
    row.idx  = idx;
    row.val  = val;
    return row;
  endfunction

  function automatic stim_row_t req_row(input strain_req_t req);
    stim_row_t row;
    row      = '0;
    row.kind = ROW_REQ;
    row.req  = req;
    return row;
  endfunction

  function automatic stim_row_t chk_row(input strain_req_t req, input stress_res_t want);
    stim_row_t row;
    row      = '0;
    row.kind = ROW_CHK;
    row.req  = req;
    row.want = want;
    return row;
  endfunction

  // Strain mix: extremes, full-range noise, and physically small strains.
  function automatic logic [31:0] rand_strain();
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0:       v = 32'h7fff_ffff;
      1:       v = 32'h8000_0000;
      2:       v = 32'h0;
      3, 4, 5: v = $urandom;
      default: v = $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
    endcase
    return v;
  endfunction

  function automatic logic [15:0] rand_dt();
    logic [15:0] v;
    case ($urandom_range(0, 7))
      0:       v = 16'h7fff;
      1:       v = 16'h8000;
      2:       v = 16'h0;     // plain Hooke's law
      default: v = 16'($urandom);
    endcase
    return v;
  endfunction

  function automatic strain_req_t rand_req();
    return mk_req(rand_strain(), rand_strain(), rand_strain(),
                  rand_strain(), rand_strain(), rand_strain(), rand_dt());
  endfunction

  function automatic logic [31:0] rand_cfg_word();
    logic [31:0] v;
    case ($urandom_range(0, 5))
      0:       v = 32'h0;
      1:       v = 32'hffff_ffff;
      2:       v = 32'h7fff_ffff;
      3:       v = 32'h8000_0000;
      4:       v = $urandom;
      default: v = $urandom_range(0, 32'h0010_0000);
    endcase
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver tasks. All entered and left just after a falling edge; every task
  // lets time pass after its last assignment so no signal is assigned twice
  // in one step.
  // ---------------------------------------------------------------------------

  // Present one request and hold it until the block takes it.
  task automatic send_req(input strain_req_t r, input logic has_want,
                          input stress_res_t want);
    start                <= 1'b1;
    strain_xx_i          <= r.xx;
    strain_yy_i          <= r.yy;
    strain_zz_i          <= r.zz;
    strain_xy_i          <= r.xy;
    strain_xz_i          <= r.xz;
    strain_yz_i          <= r.yz;
    temperature_change_i <= r.dt;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    pending_stress.push_back(has_want ? want : calc_stress(r));
    @(negedge clk_i);
  endtask

  // Drop start, with junk on the payload, for a pause of length n (n >= 1).
  task automatic pause(input int n);
    start                <= 1'b0;
    strain_xx_i          <= $urandom;
    strain_yy_i          <= $urandom;
    strain_zz_i          <= $urandom;
    strain_xy_i          <= $urandom;
    strain_xz_i          <= $urandom;
    strain_yz_i          <= $urandom;
    temperature_change_i <= 16'($urandom);
    repeat (n) @(negedge clk_i);
  endtask

  // Sender idle between requests; burst mode keeps start high back to back.
  task automatic sender_gap(input logic burst);
    int gap;
    gap = burst ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) pause(gap);
  endtask

  // Wait until every request in flight has produced its result, then let the
  // pipeline run empty for its full depth.
  task automatic drain();
    start <= 1'b0;
    @(negedge clk_i);
    while (pending_stress.size() != 0) @(negedge clk_i);
    repeat (PIPE_LAT) @(negedge clk_i);
  endtask

  // One register write; the shadow copy follows the block's masking.
  task automatic write_cfg(input cfg_reg_e idx, input logic [31:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    case (idx)
      CFG_LAMBDA: cur_lambda = val;
      CFG_MU:     cur_mu     = val[30:0];
      CFG_ALPHA:  cur_alpha  = val;
      default:    ;   // unmapped index, nothing changes
    endcase
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= $urandom;
    @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------
  task automatic log_mismatch(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= MAX_REPORTS) $display("MISMATCH: %s", msg);
  endtask

  task automatic cmp_field(input string name, input logic signed [OutW-1:0] want,
                           input logic signed [OutW-1:0] got);
    if (got !== want)
      log_mismatch($sformatf("%s expected %0d got %0d", name, want, got));
  endtask

  always @(posedge clk_i) begin : result_check
    stress_res_t want;
    if (rst_ni && valid_o) begin
      if (pending_stress.size() == 0) begin
        log_mismatch("result with no request pending");
      end else begin
        want = pending_stress.pop_front();
        cmp_field("stress_xx", want.sxx, stress_xx_o);
        cmp_field("stress_yy", want.syy, stress_yy_o);
        cmp_field("stress_zz", want.szz, stress_zz_o);
        cmp_field("stress_xy", want.sxy, stress_xy_o);
        cmp_field("stress_xz", want.sxz, stress_xz_o);
        cmp_field("stress_yz", want.syz, stress_yz_o);
        cmp_field("energy_density", want.energy, energy_density_o);
      end
    end
  end

  // Watchdog: any accepted request, result or register write counts as progress.
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || valid_o || cfg_we_i) begin
      stall_cnt <= 0;
    end else begin
      stall_cnt <= stall_cnt + 1;
      if (stall_cnt >= STALL_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    stim_row_t row;
    int        i;
    int        ph;
    int        n;
    logic      burst;

    rst_ni               = 1'b0;
    start                = 1'b0;
    strain_xx_i          = '0;
    strain_yy_i          = '0;
    strain_zz_i          = '0;
    strain_xy_i          = '0;
    strain_xz_i          = '0;
    strain_yz_i          = '0;
    temperature_change_i = '0;
    cfg_we_i             = 1'b0;
    cfg_idx_i            = CFG_LAMBDA;
    cfg_wdata_i          = '0;
    cur_lambda           = '0;
    cur_mu               = '0;
    cur_alpha            = '0;
    mismatch_cnt         = 0;
    stall_cnt            = 0;

    // --- directed table ---
    // Registers clear on reset, so any strain and any temperature rise give zero.
    stim_tab.push_back(chk_row(mk_req(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                                      32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                                      16'h7fff), '0));
    stim_tab.push_back(chk_row(mk_req(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                      32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                      16'h8000), '0));
    // mu = 0.5 MPa, unit strain xx: sigma_xx = 1 MPa, W = 0.5 MPa
    stim_tab.push_back(cfg_row(CFG_MU, 32'd128));
    stim_tab.push_back(chk_row(mk_req(32'h4000_0000, 32'h0, 32'h0, 32'h0, 32'h0,
                                      32'h0, 16'h0),
                               mk_res(48'sd256, 48'sd0, 48'sd0, 48'sd0, 48'sd0,
                                      48'sd0, 48'sd128)));
    // Most negative lambda, no shear modulus, full negative volumetric strain:
    // sigma_ii = 3*2^32 raw, energy goes negative (-9*2^32 raw).
    stim_tab.push_back(cfg_row(CFG_MU, 32'd0));
    stim_tab.push_back(cfg_row(CFG_LAMBDA, 32'h8000_0000));
    stim_tab.push_back(chk_row(mk_req(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                      32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                      16'h7fff),
                               mk_res(48'sd12884901888, 48'sd12884901888,
                                      48'sd12884901888, 48'sd0, 48'sd0, 48'sd0,
                                      -48'sd38654705664)));
    // All registers at their top; mu write has bit 31 set and must be masked.
    stim_tab.push_back(cfg_row(CFG_LAMBDA, 32'h7fff_ffff));
    stim_tab.push_back(cfg_row(CFG_MU, 32'hffff_ffff));
    stim_tab.push_back(cfg_row(CFG_ALPHA, 32'hffff_ffff));
    stim_tab.push_back(req_row(mk_req(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                                      32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                                      16'h7fff)));
    stim_tab.push_back(req_row(mk_req(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                      32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                      16'h8000)));
    stim_tab.push_back(req_row(mk_req(32'h7fff_ffff, 32'h8000_0000, 32'h0,
                                      32'h8000_0000, 32'h7fff_ffff, 32'h1, 16'h0)));
    stim_tab.push_back(req_row(mk_req(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
                                      16'h7fff)));
    stim_tab.push_back(req_row(mk_req(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
                                      16'h8000)));
    stim_tab.push_back(req_row(mk_req(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                                      32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                                      16'hffff)));
    // Write to the unmapped index must leave every register alone.
    stim_tab.push_back(cfg_row(CFG_SPARE, 32'hdead_beef));
    stim_tab.push_back(req_row(mk_req(32'h1234_5678, 32'hedcb_a988, 32'h0bad_f00d,
                                      32'h5555_5555, 32'haaaa_aaaa, 32'h0f0f_0f0f,
                                      16'h5a5a)));
    // Rounding ties: 2*mu*eps lands exactly on half an output step.
    stim_tab.push_back(cfg_row(CFG_LAMBDA, 32'h0));
    stim_tab.push_back(cfg_row(CFG_MU, 32'd1));
    stim_tab.push_back(cfg_row(CFG_ALPHA, 32'h0));
    stim_tab.push_back(req_row(mk_req(32'h1000_0000, 32'hf000_0000, 32'h3000_0000,
                                      32'h1000_0000, 32'hf000_0000, 32'h3000_0000,
                                      16'h0)));
    stim_tab.push_back(req_row(mk_req(32'hd000_0000, 32'h3000_0000, 32'hd000_0000,
                                      32'hd000_0000, 32'h1000_0000, 32'hf000_0000,
                                      16'h0)));
    // Steel-like constants with a small negative lambda, moderate strain and heat.
    stim_tab.push_back(cfg_row(CFG_LAMBDA, 32'hffff_fd00));
    stim_tab.push_back(cfg_row(CFG_MU, 32'd1280));
    stim_tab.push_back(cfg_row(CFG_ALPHA, 32'd13194140));
    stim_tab.push_back(req_row(mk_req(32'd1073742, 32'd1073742, 32'd1073742,
                                      32'hfffb_e5b3, 32'd536871, 32'h0, 16'd1600)));
    stim_tab.push_back(req_row(mk_req(32'hfff0_0000, 32'd2097152, 32'h0,
                                      32'h0, 32'h0, 32'd4096, 16'hf9c0)));

    // Reset is held from time zero and released on a falling edge.
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (i = 0; i < stim_tab.size(); i++) begin
      row = stim_tab[i];
      if (row.kind == ROW_CFG) begin
        drain();
        write_cfg(row.idx, row.val);
      end else begin
        send_req(row.req, row.kind == ROW_CHK, row.want);
        sender_gap(1'b0);
      end
    end

    // --- random phases, each with its own register setting ---
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      drain();
      case (ph)
        0: begin   // everything at its top
          write_cfg(CFG_LAMBDA, 32'h7fff_ffff);
          write_cfg(CFG_MU, 32'h7fff_ffff);
          write_cfg(CFG_ALPHA, 32'hffff_ffff);
        end
        1: begin   // most negative lambda, no shear stiffness
          write_cfg(CFG_LAMBDA, 32'h8000_0000);
          write_cfg(CFG_MU, 32'h0);
          write_cfg(CFG_ALPHA, 32'hffff_ffff);
        end
        default: begin
          write_cfg(CFG_LAMBDA, rand_cfg_word());
          write_cfg(CFG_MU, rand_cfg_word());
          write_cfg(CFG_ALPHA, rand_cfg_word());
          if ($urandom_range(0, 1) == 0) write_cfg(CFG_SPARE, $urandom);
        end
      endcase
      // odd phases run back to back, even phases with random sender gaps
      burst = ph[0];
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        send_req(rand_req(), 1'b0, '0);
        // now and then hold off until the pipeline has emptied
        if ($urandom_range(0, 63) == 0) drain();
        else sender_gap(burst);
      end
    end

    drain();
    repeat (PIPE_LAT + 4) @(negedge clk_i);
    if (mismatch_cnt == 0 && pending_stress.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/ites_pkg.sv
rtl/core/ites_lane.sv
rtl/core/ites_volume.sv
rtl/core/ites_merge.sv
rtl/core/isotropic_thermoelastic_stress.sv
dv/tb_top.sv
